FILE: hw/rtl/twrtc_pkg.sv
package twrtc_pkg;

    localparam int IN_W  = 24;
    localparam int OUT_W = 16;

    localparam logic [2:0] OP_GET     = 3'd0;
    localparam logic [2:0] OP_SET     = 3'd1;
    localparam logic [2:0] OP_RAM_RD  = 3'd2;
    localparam logic [2:0] OP_RAM_WR  = 3'd3;
    localparam logic [2:0] OP_HALT    = 3'd4;
    localparam logic [2:0] OP_UNPROT  = 3'd5;
    localparam logic [2:0] OP_FORMAT  = 3'd6;

    localparam logic [3:0] FLD_SEC    = 4'd0;
    localparam logic [3:0] FLD_MIN    = 4'd1;
    localparam logic [3:0] FLD_HOUR   = 4'd2;
    localparam logic [3:0] FLD_DATE   = 4'd3;
    localparam logic [3:0] FLD_MONTH  = 4'd4;
    localparam logic [3:0] FLD_WDAY   = 4'd5;
    localparam logic [3:0] FLD_YEAR   = 4'd6;
    localparam logic [3:0] FLD_MODE   = 4'd7;
    localparam logic [3:0] FLD_RUN    = 4'd8;

    localparam logic [3:0] KIND_RAW   = 4'd9;

    localparam logic [7:0] CMD_CLOCK_BASE = 8'h80;
    localparam logic [7:0] CMD_SEC_WR     = 8'h80;
    localparam logic [7:0] CMD_SEC_RD     = 8'h81;
    localparam logic [7:0] CMD_HOUR_WR    = 8'h84;
    localparam logic [7:0] CMD_HOUR_RD    = 8'h85;
    localparam logic [7:0] CMD_WP_WR      = 8'h8E;
    localparam logic [1:0] CMD_RAM_TOP    = 2'b11;

    localparam logic [7:0] HALT_BIT   = 8'h80;
    localparam logic [7:0] MODE12_BIT = 8'h80;
    localparam logic [7:0] PM_BIT     = 8'h20;

    localparam logic [1:0] RAM_LAST_BANK = 2'd3;
    localparam logic [2:0] RAM_LAST_SLOT = 3'd7;

    typedef struct packed {
        logic       ok;
        logic       is_read;
        logic [3:0] kind;
        logic [7:0] command;
        logic [7:0] data;
    } req_t;

endpackage

FILE: hw/rtl/three_wire_rtc_bcd_master_core.sv
// three-wire serial clock chip master, one beat in, one beat out
// s_ channel: a beat with tuser 0 is a request (operation, field, value,
// 12-hour flag, ram page and byte); tuser 1 is one serial bit slot and
// carries the sampled data line level in io_sample
// m_ channel: one beat per input beat, giving chip enable, data line drive
// enable and level, a reject flag and the decoded read value; tlast marks
// the beat that ends a transaction (sixteenth slot or a request refused while idle)
// a transaction is a request followed by sixteen slots: eight command bits
// driven lsb first, then eight data bits driven or sampled
// each input beat passes through one input register, then the encode, shift
// and bcd decode logic feeding the output register
// throughput is one beat per cycle while m_tready is high, set by the single pass
// through that logic with the transaction state updated as each beat moves on
// reset clears both registers and leaves the master idle with chip enable low
// when the receiver stalls, the output register holds its beat, the input
// register fills and then s_tready drops until m_tready returns
module three_wire_rtc_bcd_master_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // op, field, value, twelve_hour, ram_bank, ram_slot, io_sample, zero pad
    input  logic [twrtc_pkg::IN_W-1:0]   s_tdata,
    // func
    input  logic [0:0]                   s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // chip_enable, drive_enable, drive_level, rejected, read_result, zero pad
    output logic [twrtc_pkg::OUT_W-1:0]  m_tdata,
    // done_res
    output logic                         m_tlast
);

    logic                        in_valid_reg;
    logic                        in_func_reg;
    logic [twrtc_pkg::IN_W-1:0]  in_data_reg;
    logic                        advance;

    logic                        m_valid_reg;
    logic [twrtc_pkg::OUT_W-1:0] m_data_reg;
    logic                        m_last_reg;

    logic       active_reg,   active_next;
    logic [3:0] slot_reg,     slot_next;
    logic [7:0] command_reg,  command_next;
    logic [7:0] data_reg,     data_next;
    logic [7:0] shift_reg,    shift_next;
    logic       is_read_reg,  is_read_next;
    logic [3:0] kind_reg,     kind_next;

    logic [2:0] in_op;
    logic [3:0] in_field;
    logic [7:0] in_value;
    logic       in_twelve;
    logic [1:0] in_bank;
    logic [2:0] in_slot;
    logic       in_io;

    twrtc_pkg::req_t req;
    logic [7:0] sample_byte;
    logic [7:0] dec_result;

    logic       ce, de, lvl, done, rej;
    logic [7:0] res;

    assign in_op     = in_data_reg[2:0];
    assign in_field  = in_data_reg[6:3];
    assign in_value  = in_data_reg[14:7];
    assign in_twelve = in_data_reg[15];
    assign in_bank   = in_data_reg[17:16];
    assign in_slot   = in_data_reg[20:18];
    assign in_io     = in_data_reg[21];

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    twrtc_req_enc u_enc (
        .op          (in_op),
        .field       (in_field),
        .value       (in_value),
        .twelve_hour (in_twelve),
        .ram_bank    (in_bank),
        .ram_slot    (in_slot),
        .req         (req)
    );

    assign sample_byte = shift_reg | (8'(in_io) << slot_reg[2:0]);

    twrtc_bcd_dec u_dec (
        .kind   (kind_reg),
        .raw    (sample_byte),
        .result (dec_result)
    );

    always_comb begin
        ce           = 1'b0;
        de           = 1'b0;
        lvl          = 1'b0;
        done         = 1'b0;
        rej          = 1'b0;
        res          = 8'd0;
        active_next  = active_reg;
        slot_next    = slot_reg;
        command_next = command_reg;
        data_next    = data_reg;
        shift_next   = shift_reg;
        is_read_next = is_read_reg;
        kind_next    = kind_reg;
        if (!in_func_reg) begin
            if (active_reg) begin
                ce  = 1'b1;
                rej = 1'b1;
            end else if (req.ok) begin
                ce           = 1'b1;
                active_next  = 1'b1;
                slot_next    = 4'd0;
                shift_next   = 8'd0;
                command_next = req.command;
                data_next    = req.data;
                is_read_next = req.is_read;
                kind_next    = req.kind;
            end else begin
                rej  = 1'b1;
                done = 1'b1;
            end
        end else if (active_reg) begin
            ce = 1'b1;
            if (!slot_reg[3]) begin
                de  = 1'b1;
                lvl = command_reg[slot_reg[2:0]];
            end else if (is_read_reg) begin
                shift_next = sample_byte;
            end else begin
                de  = 1'b1;
                lvl = data_reg[slot_reg[2:0]];
            end
            if (slot_reg == 4'd15) begin
                done        = 1'b1;
                res         = is_read_reg ? dec_result : 8'd0;
                active_next = 1'b0;
                slot_next   = 4'd0;
            end else begin
                slot_next = slot_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_func_reg <= s_tuser[0];
            in_data_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            slot_reg    <= 4'd0;
            command_reg <= 8'd0;
            data_reg    <= 8'd0;
            shift_reg   <= 8'd0;
            is_read_reg <= 1'b0;
            kind_reg    <= 4'd0;
        end else if (advance) begin
            active_reg  <= active_next;
            slot_reg    <= slot_next;
            command_reg <= command_next;
            data_reg    <= data_next;
            shift_reg   <= shift_next;
            is_read_reg <= is_read_next;
            kind_reg    <= kind_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (advance) begin
            m_data_reg <= {4'b0000, res, rej, lvl, de, ce};
            m_last_reg <= done;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    a_slot_needs_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (slot_reg != 4'd0) |-> active_reg)
        else $error("slot counter running while idle");

    a_refused_ce_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[3]) |-> (m_last_reg == !m_data_reg[0]))
        else $error("reject beat with wrong chip enable or last flag");

    a_level_needs_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg[1]) |-> !m_data_reg[2])
        else $error("drive level set while not driving");

    a_result_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg[11:4] != 8'd0)) |-> (m_last_reg && m_data_reg[0]))
        else $error("read value outside the final slot");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid_reg && !in_valid_reg && !active_reg))
        else $error("pipeline not empty after reset");

endmodule

FILE: hw/rtl/twrtc_req_enc.sv
module twrtc_req_enc (
    input  logic [2:0]       op,
    input  logic [3:0]       field,
    input  logic [7:0]       value,
    input  logic             twelve_hour,
    input  logic [1:0]       ram_bank,
    input  logic [2:0]       ram_slot,
    output twrtc_pkg::req_t  req
);

    function automatic logic [7:0] to_bcd(input logic [7:0] v);
        logic [15:0] prod;
        logic [3:0]  q;
        logic [7:0]  r;
        prod = 16'(v) * 16'd205;
        q    = prod[14:11];
        r    = v - ({1'b0, q, 3'b000} + {3'b000, q, 1'b0});
        return {q, r[3:0]};
    endfunction

    logic [7:0] h12;
    logic [7:0] pm;

    always_comb begin
        h12 = (value >= 8'd12) ? (value - 8'd12) : value;
        if (h12 == 8'd0) begin
            h12 = 8'd12;
        end
        pm = (value >= 8'd12) ? twrtc_pkg::PM_BIT : 8'h00;
    end

    always_comb begin
        req = '0;
        unique case (op)
            twrtc_pkg::OP_GET: begin
                if (field <= twrtc_pkg::FLD_RUN) begin
                    req.ok      = 1'b1;
                    req.is_read = 1'b1;
                    req.kind    = field;
                    if (field == twrtc_pkg::FLD_MODE) begin
                        req.command = twrtc_pkg::CMD_HOUR_RD;
                    end else if (field == twrtc_pkg::FLD_RUN) begin
                        req.command = twrtc_pkg::CMD_SEC_RD;
                    end else begin
                        req.command = twrtc_pkg::CMD_CLOCK_BASE
                                    | {4'b0000, field[2:0], 1'b1};
                    end
                end
            end
            twrtc_pkg::OP_SET: begin
                req.command = twrtc_pkg::CMD_CLOCK_BASE | {4'b0000, field[2:0], 1'b0};
                case (field) inside
                    twrtc_pkg::FLD_SEC, twrtc_pkg::FLD_MIN: begin
                        req.ok   = (value <= 8'd59);
                        req.data = to_bcd(value);
                    end
                    twrtc_pkg::FLD_HOUR: begin
                        req.ok   = (value <= 8'd23);
                        req.data = twelve_hour ? (twrtc_pkg::MODE12_BIT | pm | to_bcd(h12))
                                               : to_bcd(value);
                    end
                    twrtc_pkg::FLD_DATE: begin
                        req.ok   = (value != 8'd0) && (value <= 8'd31);
                        req.data = to_bcd(value);
                    end
                    twrtc_pkg::FLD_MONTH: begin
                        req.ok   = (value != 8'd0) && (value <= 8'd12);
                        req.data = to_bcd(value);
                    end
                    twrtc_pkg::FLD_WDAY: begin
                        req.ok   = (value != 8'd0) && (value <= 8'd7);
                        req.data = value;
                    end
                    twrtc_pkg::FLD_YEAR: begin
                        req.ok   = (value <= 8'd99);
                        req.data = to_bcd(value);
                    end
                    twrtc_pkg::FLD_MODE: begin
                        req.ok      = (value <= 8'd1);
                        req.command = twrtc_pkg::CMD_HOUR_WR;
                        req.data    = value[0] ? 8'h00 : twrtc_pkg::MODE12_BIT;
                    end
                    twrtc_pkg::FLD_RUN: begin
                        req.ok      = (value <= 8'd1);
                        req.command = twrtc_pkg::CMD_SEC_WR;
                        req.data    = value[0] ? 8'h00 : twrtc_pkg::HALT_BIT;
                    end
                    default: begin
                        req.ok = 1'b0;
                    end
                endcase
            end
            twrtc_pkg::OP_RAM_RD, twrtc_pkg::OP_RAM_WR: begin
                req.ok = !((ram_bank == twrtc_pkg::RAM_LAST_BANK)
                        && (ram_slot == twrtc_pkg::RAM_LAST_SLOT));
                if (op == twrtc_pkg::OP_RAM_RD) begin
                    req.command = {twrtc_pkg::CMD_RAM_TOP, ram_bank, ram_slot, 1'b1};
                    req.is_read = 1'b1;
                    req.kind    = twrtc_pkg::KIND_RAW;
                end else begin
                    req.command = {twrtc_pkg::CMD_RAM_TOP, ram_bank, ram_slot, 1'b0};
                    req.data    = value;
                end
            end
            twrtc_pkg::OP_HALT: begin
                req.ok      = (value <= 8'd1);
                req.command = twrtc_pkg::CMD_SEC_WR;
                req.data    = value[0] ? twrtc_pkg::HALT_BIT : 8'h00;
            end
            twrtc_pkg::OP_UNPROT: begin
                req.ok      = 1'b1;
                req.command = twrtc_pkg::CMD_WP_WR;
            end
            twrtc_pkg::OP_FORMAT: begin
                req.ok      = (value <= 8'd1);
                req.command = twrtc_pkg::CMD_HOUR_WR;
                req.data    = value[0] ? 8'h00 : twrtc_pkg::MODE12_BIT;
            end
            default: begin
                req.ok = 1'b0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/twrtc_bcd_dec.sv
module twrtc_bcd_dec (
    input  logic [3:0] kind,
    input  logic [7:0] raw,
    output logic [7:0] result
);

    logic [3:0] tens;
    logic [3:0] ones;
    logic       numeric;

    assign ones = raw[3:0];

    always_comb begin
        tens    = 4'd0;
        numeric = 1'b1;
        result  = raw;
        unique case (kind) inside
            twrtc_pkg::FLD_SEC, twrtc_pkg::FLD_MIN: begin
                tens = {1'b0, raw[6:4]};
            end
            twrtc_pkg::FLD_HOUR: begin
                tens = raw[7] ? {3'b000, raw[4]} : {2'b00, raw[5:4]};
            end
            twrtc_pkg::FLD_DATE: begin
                tens = {2'b00, raw[5:4]};
            end
            twrtc_pkg::FLD_MONTH: begin
                tens = {3'b000, raw[4]};
            end
            twrtc_pkg::FLD_WDAY: begin
                numeric = 1'b0;
                result  = {5'b00000, raw[2:0]};
            end
            twrtc_pkg::FLD_YEAR: begin
                tens = raw[7:4];
            end
            twrtc_pkg::FLD_MODE: begin
                numeric = 1'b0;
                result  = raw[7] ? (raw[5] ? 8'd2 : 8'd1) : 8'd0;
            end
            twrtc_pkg::FLD_RUN: begin
                numeric = 1'b0;
                result  = raw[7] ? 8'd0 : 8'd1;
            end
            default: begin
                numeric = 1'b0;
                result  = raw;
            end
        endcase
        if (numeric) begin
            result = {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0} + {4'b0000, ones};
        end
    end

endmodule
